/* rtl/core/tfdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdt_pkg
// Shared types and constants of the triangle fragment depth test.
// ----------------------------------------------------------------------------
package tfdt_pkg;

    // wide product / dividend width
    localparam int XW = 128;
    // denominator sum of three n*w*w terms
    localparam int DEN_W = 108;
    localparam int QZ_W = 32;
    localparam logic [5:0] QZ_BITS = 6'd32;
    localparam logic [5:0] QW_BITS = 6'd16;
    localparam logic [31:0] DEPTH_RESET = 32'h8000_0000;
    localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;
    localparam logic [16:0] WEIGHT_ONE = 17'd32768;

    // signed width of a vertex/pixel difference
    function automatic int diff_width(input int sb);
        int w;
        w = (sb + 12 > 17) ? sb + 12 : 17;
        return w;
    endfunction

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEOM,
        ST_CLASS,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MEM_RD,
        ST_MEM_CMP,
        ST_DONE
    } t_state;

    // multiply sequence: each step is (operand) * w
    typedef enum logic [3:0] {
        MS_A0  = 4'd0,  // n0 * w1
        MS_P0  = 4'd1,  // * w2
        MS_A1  = 4'd2,  // n1 * w0
        MS_P1  = 4'd3,  // * w2
        MS_A2  = 4'd4,  // n2 * w0
        MS_P2  = 4'd5,  // * w1
        MS_D0  = 4'd6,  // d * w1
        MS_D1  = 4'd7,  // * w2
        MS_NUM = 4'd8   // * w0
    } t_mstep;

    typedef enum logic [1:0] {
        DS_Z,
        DS_W0,
        DS_W1,
        DS_W2
    } t_dstep;

endpackage

/* rtl/core/tfdt_geom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdt_geom
// Edge cross products, sign normalization, degeneracy and coverage test.
// ----------------------------------------------------------------------------
module tfdt_geom #(
    parameter int SUBPIXEL_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_x0,
    input  logic signed [15:0]   i_y0,
    input  logic signed [15:0]   i_x1,
    input  logic signed [15:0]   i_y1,
    input  logic signed [15:0]   i_x2,
    input  logic signed [15:0]   i_y2,
    input  logic [9:0]           i_px,
    input  logic [9:0]           i_py,
    output logic [2*tfdt_pkg::diff_width(SUBPIXEL_BITS)+3:0] o_n0,
    output logic [2*tfdt_pkg::diff_width(SUBPIXEL_BITS)+3:0] o_n1,
    output logic [2*tfdt_pkg::diff_width(SUBPIXEL_BITS)+3:0] o_n2,
    output logic [2*tfdt_pkg::diff_width(SUBPIXEL_BITS)+3:0] o_d,
    output logic                 o_covered
);
    localparam int DW = tfdt_pkg::diff_width(SUBPIXEL_BITS);
    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + 4;
    localparam logic signed [NW-1:0] MIN_AREA = NW'(1) <<< (2 * SUBPIXEL_BITS);

    logic [DW-1:0]        pxs, pys;
    logic signed [DW-1:0] ax, ay, az, bx, by, bz;
    logic signed [PW-1:0] r_ay_bz, r_az_by, r_az_bx, r_ax_bz, r_ax_by, r_ay_bx;
    logic signed [NW-1:0] ux, uy, uz, sx, sy, sz, n0;
    logic                 neg, degen;

    always_comb begin
        pxs = DW'(i_px) << SUBPIXEL_BITS;
        pys = DW'(i_py) << SUBPIXEL_BITS;
        ax = DW'(i_x2) - DW'(i_x0);
        ay = DW'(i_x1) - DW'(i_x0);
        az = DW'(i_x0) - $signed(pxs);
        bx = DW'(i_y2) - DW'(i_y0);
        by = DW'(i_y1) - DW'(i_y0);
        bz = DW'(i_y0) - $signed(pys);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ay_bz <= ay * bz;
            r_az_by <= az * by;
            r_az_bx <= az * bx;
            r_ax_bz <= ax * bz;
            r_ax_by <= ax * by;
            r_ay_bx <= ay * bx;
        end
    end

    always_comb begin
        ux = NW'(r_ay_bz) - NW'(r_az_by);
        uy = NW'(r_az_bx) - NW'(r_ax_bz);
        uz = NW'(r_ax_by) - NW'(r_ay_bx);
        neg = uz[NW-1];
        sx = neg ? -ux : ux;
        sy = neg ? -uy : uy;
        sz = neg ? -uz : uz;
        degen = sz < MIN_AREA;
        n0 = sz - sx - sy;
        o_covered = !degen && !n0[NW-1] && !sy[NW-1] && !sx[NW-1];
        o_n0 = n0;
        o_n1 = sy;
        o_n2 = sx;
        o_d = sz;
    end

endmodule

/* rtl/core/tfdt_mulw.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdt_mulw
// Wide operand times 31-bit w, one 32x31 partial product per cycle.
// ----------------------------------------------------------------------------
module tfdt_mulw (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tfdt_pkg::XW-1:0]   i_x,
    input  logic [30:0]               i_w,
    output logic                      o_done,
    output logic [tfdt_pkg::XW-1:0]   o_acc
);
    logic [tfdt_pkg::XW-1:0] r_x, r_acc;
    logic [30:0]             r_w;
    logic [1:0]              r_k;
    logic                    r_busy, r_done;
    logic [62:0]             prod;

    assign prod = r_x[{r_k, 5'b0} +: 32] * r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_busy && (r_k == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_w   <= i_w;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + (tfdt_pkg::XW'(prod) << {r_k, 5'b0});
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

/* rtl/core/tfdt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdt_div
// Restoring divider, one quotient bit per cycle, 32 or 16 quotient bits.
// ----------------------------------------------------------------------------
module tfdt_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_wide,
    input  logic [tfdt_pkg::XW-1:0]      i_num,
    input  logic [tfdt_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [tfdt_pkg::QZ_W-1:0]    o_quot
);
    localparam int DEN_W = tfdt_pkg::DEN_W;

    logic [DEN_W-1:0] r_rem, r_den;
    logic [31:0]      r_low, r_q;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    // quotient is known to fit, so the top of the dividend starts below den
    always_comb begin
        trial = {r_rem, r_low[31]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_wide ? tfdt_pkg::QZ_BITS : tfdt_pkg::QW_BITS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_q   <= '0;
            if (i_wide) begin
                r_rem <= DEN_W'(i_num >> 32);
                r_low <= i_num[31:0];
            end else begin
                r_rem <= DEN_W'(i_num >> 16);
                r_low <= {i_num[15:0], 16'b0};
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_low <= r_low << 1;
            r_q   <= {r_q[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/core/tfdt_zbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfdt_zbuf
// Depth memory, one write and one registered read port, clear sweep on reset.
// ----------------------------------------------------------------------------
module tfdt_zbuf #(
    parameter int ENTRIES = 65536,
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    output logic          o_clr_busy
);
    logic [31:0]   r_mem [ENTRIES];
    logic [31:0]   r_rd_data;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(ENTRIES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= tfdt_pkg::DEPTH_RESET;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

/* rtl/core/triangle_fragment_depth_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_fragment_depth_test
// Per-pixel coverage, perspective-correct depth and weights, z-buffer test.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  in      | i_in_valid / o_in_stall   | vertices, clip w, pixel
//  out     | o_out_valid / i_out_stall | off_screen, covered, depth_written,
//          |                           | weight0..2, frag_depth
//
// One request at a time. An off-screen pixel goes straight to the result; an
// uncovered one stops after the geometry test. A covered pixel runs nine wide
// multiplies (four partial products each) on one 32x31 multiplier, then one
// 32-bit and three 16-bit restoring divisions on a shared one-bit-per-cycle
// divider, then a read and, if the depth test passes, a write of the depth memory.
// After reset the depth memory is swept over all SCREEN_WIDTH*SCREEN_HEIGHT
// entries with o_in_stall high. A stalled result sits in the output register while
// the next request is accepted and processed.
// ----------------------------------------------------------------------------
module triangle_fragment_depth_test #(
    parameter int SCREEN_WIDTH = 256,
    parameter int SCREEN_HEIGHT = 256,
    parameter int SUBPIXEL_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_vert0_x,
    input  logic signed [15:0] i_vert0_y,
    input  logic signed [15:0] i_vert1_x,
    input  logic signed [15:0] i_vert1_y,
    input  logic signed [15:0] i_vert2_x,
    input  logic signed [15:0] i_vert2_y,
    input  logic [30:0]        i_clip_w0,
    input  logic [30:0]        i_clip_w1,
    input  logic [30:0]        i_clip_w2,
    input  logic [9:0]         i_pixel_x,
    input  logic [9:0]         i_pixel_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_off_screen,
    output logic               o_covered,
    output logic               o_depth_written,
    output logic [15:0]        o_weight0,
    output logic [15:0]        o_weight1,
    output logic [15:0]        o_weight2,
    output logic [30:0]        o_frag_depth
);
    localparam int ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = 2 * tfdt_pkg::diff_width(SUBPIXEL_BITS) + 4;
    localparam int XW = tfdt_pkg::XW;
    localparam int DEN_W = tfdt_pkg::DEN_W;
    localparam logic [10:0] LIM_X = 11'(SCREEN_WIDTH);
    localparam logic [10:0] LIM_Y = 11'(SCREEN_HEIGHT);

    tfdt_pkg::t_state r_state, n_state;
    tfdt_pkg::t_mstep r_mstep;
    tfdt_pkg::t_dstep r_dstep;

    logic signed [15:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [30:0]        r_w0, r_w1, r_w2;
    logic [9:0]         r_px, r_py;
    logic [AW-1:0]      r_addr;
    logic               r_off, r_cov, r_written;
    logic [NW-1:0]      r_n0, r_n1, r_n2, r_d;
    logic [DEN_W-1:0]   r_p0, r_p1, r_p2;
    logic [XW-1:0]      r_num;
    logic [30:0]        r_z;
    logic [15:0]        r_wt0, r_wt1, r_wt2;

    logic               r_out_valid, r_o_off, r_o_cov, r_o_wr;
    logic [15:0]        r_o_w0, r_o_w1, r_o_w2;
    logic [30:0]        r_o_z;

    logic               accept, in_off, out_free, out_load;
    logic               geom_en, mul_start, div_start, rd_en, wr_en, pass;
    logic [NW-1:0]      g_n0, g_n1, g_n2, g_d;
    logic               g_cov, clr_busy;
    logic [XW-1:0]      mul_x, mul_acc, div_num;
    logic [30:0]        mul_w;
    logic               mul_done, div_done, div_wide;
    logic [DEN_W-1:0]   den;
    logic [31:0]        div_q, rd_data;

    assign in_off   = ({1'b0, i_pixel_x} >= LIM_X) || ({1'b0, i_pixel_y} >= LIM_Y);
    assign out_free = !r_out_valid || !i_out_stall;
    assign den      = r_p0 + r_p1 + r_p2;
    assign pass     = $signed(rd_data) < $signed({1'b0, r_z});

    tfdt_geom #(
        .SUBPIXEL_BITS(SUBPIXEL_BITS)
    ) u_geom (
        .i_clk     (i_clk),
        .i_en      (geom_en),
        .i_x0      (r_x0),
        .i_y0      (r_y0),
        .i_x1      (r_x1),
        .i_y1      (r_y1),
        .i_x2      (r_x2),
        .i_y2      (r_y2),
        .i_px      (r_px),
        .i_py      (r_py),
        .o_n0      (g_n0),
        .o_n1      (g_n1),
        .o_n2      (g_n2),
        .o_d       (g_d),
        .o_covered (g_cov)
    );

    tfdt_mulw u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_w     (mul_w),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    tfdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_wide  (div_wide),
        .i_num   (div_num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    tfdt_zbuf #(
        .ENTRIES(ENTRIES),
        .AW     (AW)
    ) u_zbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_addr),
        .i_wr_data  ({1'b0, r_z}),
        .o_clr_busy (clr_busy)
    );

    // multiply operand selection
    always_comb begin
        case (r_mstep)
            tfdt_pkg::MS_A0: begin
                mul_x = XW'(r_n0);
                mul_w = r_w1;
            end
            tfdt_pkg::MS_P0: begin
                mul_x = mul_acc;
                mul_w = r_w2;
            end
            tfdt_pkg::MS_A1: begin
                mul_x = XW'(r_n1);
                mul_w = r_w0;
            end
            tfdt_pkg::MS_P1: begin
                mul_x = mul_acc;
                mul_w = r_w2;
            end
            tfdt_pkg::MS_A2: begin
                mul_x = XW'(r_n2);
                mul_w = r_w0;
            end
            tfdt_pkg::MS_P2: begin
                mul_x = mul_acc;
                mul_w = r_w1;
            end
            tfdt_pkg::MS_D0: begin
                mul_x = XW'(r_d);
                mul_w = r_w1;
            end
            tfdt_pkg::MS_D1: begin
                mul_x = mul_acc;
                mul_w = r_w2;
            end
            default: begin
                mul_x = mul_acc;
                mul_w = r_w0;
            end
        endcase
    end

    always_comb begin
        div_wide = 1'b0;
        case (r_dstep)
            tfdt_pkg::DS_Z: begin
                div_num  = r_num;
                div_wide = 1'b1;
            end
            tfdt_pkg::DS_W0: div_num = XW'(r_p0) << 15;
            tfdt_pkg::DS_W1: div_num = XW'(r_p1) << 15;
            default:         div_num = XW'(r_p2) << 15;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfdt_pkg::ST_CLEAR: if (!clr_busy) n_state = tfdt_pkg::ST_IDLE;
            tfdt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_off ? tfdt_pkg::ST_DONE : tfdt_pkg::ST_GEOM;
                end
            end
            tfdt_pkg::ST_GEOM:   n_state = tfdt_pkg::ST_CLASS;
            tfdt_pkg::ST_CLASS:  n_state = g_cov ? tfdt_pkg::ST_MUL_GO : tfdt_pkg::ST_DONE;
            tfdt_pkg::ST_MUL_GO: n_state = tfdt_pkg::ST_MUL_WAIT;
            tfdt_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = (r_mstep == tfdt_pkg::MS_NUM) ? tfdt_pkg::ST_DIV_GO
                                                            : tfdt_pkg::ST_MUL_GO;
                end
            end
            tfdt_pkg::ST_DIV_GO: n_state = tfdt_pkg::ST_DIV_WAIT;
            tfdt_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_dstep == tfdt_pkg::DS_W2) ? tfdt_pkg::ST_MEM_RD
                                                           : tfdt_pkg::ST_DIV_GO;
                end
            end
            tfdt_pkg::ST_MEM_RD:  n_state = tfdt_pkg::ST_MEM_CMP;
            tfdt_pkg::ST_MEM_CMP: n_state = tfdt_pkg::ST_DONE;
            tfdt_pkg::ST_DONE:    if (out_free) n_state = tfdt_pkg::ST_IDLE;
            default:              n_state = tfdt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = (r_state != tfdt_pkg::ST_IDLE);
        accept     = (r_state == tfdt_pkg::ST_IDLE) && i_in_valid;
        geom_en    = (r_state == tfdt_pkg::ST_GEOM);
        mul_start  = (r_state == tfdt_pkg::ST_MUL_GO);
        div_start  = (r_state == tfdt_pkg::ST_DIV_GO);
        rd_en      = (r_state == tfdt_pkg::ST_MEM_RD);
        wr_en      = (r_state == tfdt_pkg::ST_MEM_CMP) && pass;
        out_load   = (r_state == tfdt_pkg::ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfdt_pkg::ST_CLEAR;
            r_mstep     <= tfdt_pkg::MS_A0;
            r_dstep     <= tfdt_pkg::DS_Z;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tfdt_pkg::ST_CLASS) begin
                r_mstep <= tfdt_pkg::MS_A0;
                r_dstep <= tfdt_pkg::DS_Z;
            end
            if (r_state == tfdt_pkg::ST_MUL_WAIT && mul_done
                && r_mstep != tfdt_pkg::MS_NUM) begin
                r_mstep <= tfdt_pkg::t_mstep'(r_mstep + 4'd1);
            end
            if (r_state == tfdt_pkg::ST_DIV_WAIT && div_done) begin
                r_dstep <= tfdt_pkg::t_dstep'(r_dstep + 2'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x0 <= i_vert0_x;
            r_y0 <= i_vert0_y;
            r_x1 <= i_vert1_x;
            r_y1 <= i_vert1_y;
            r_x2 <= i_vert2_x;
            r_y2 <= i_vert2_y;
            // zero w is taken as the smallest positive value
            r_w0 <= (i_clip_w0 == 31'd0) ? 31'd1 : i_clip_w0;
            r_w1 <= (i_clip_w1 == 31'd0) ? 31'd1 : i_clip_w1;
            r_w2 <= (i_clip_w2 == 31'd0) ? 31'd1 : i_clip_w2;
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
            r_addr <= AW'(int'(i_pixel_y) * SCREEN_WIDTH + int'(i_pixel_x));
            r_off <= in_off;
            r_cov <= 1'b0;
            r_written <= 1'b0;
        end
        if (r_state == tfdt_pkg::ST_CLASS) begin
            r_n0  <= g_n0;
            r_n1  <= g_n1;
            r_n2  <= g_n2;
            r_d   <= g_d;
            r_cov <= g_cov;
        end
        if (r_state == tfdt_pkg::ST_MUL_WAIT && mul_done) begin
            case (r_mstep)
                tfdt_pkg::MS_P0:  r_p0  <= DEN_W'(mul_acc);
                tfdt_pkg::MS_P1:  r_p1  <= DEN_W'(mul_acc);
                tfdt_pkg::MS_P2:  r_p2  <= DEN_W'(mul_acc);
                tfdt_pkg::MS_NUM: r_num <= mul_acc;
                default: ;
            endcase
        end
        if (r_state == tfdt_pkg::ST_DIV_WAIT && div_done) begin
            case (r_dstep)
                tfdt_pkg::DS_Z:  r_z <= div_q[31] ? tfdt_pkg::DEPTH_MAX : div_q[30:0];
                tfdt_pkg::DS_W0: r_wt0 <= div_q[15:0];
                tfdt_pkg::DS_W1: r_wt1 <= div_q[15:0];
                default:         r_wt2 <= div_q[15:0];
            endcase
        end
        if (r_state == tfdt_pkg::ST_MEM_CMP) begin
            r_written <= pass;
        end
        if (out_load) begin
            r_o_off <= r_off;
            r_o_cov <= r_cov && !r_off;
            r_o_wr  <= r_written && r_cov && !r_off;
            r_o_w0  <= (r_cov && !r_off) ? r_wt0 : 16'd0;
            r_o_w1  <= (r_cov && !r_off) ? r_wt1 : 16'd0;
            r_o_w2  <= (r_cov && !r_off) ? r_wt2 : 16'd0;
            r_o_z   <= (r_cov && !r_off) ? r_z : 31'd0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_off_screen    = r_o_off;
    assign o_covered       = r_o_cov;
    assign o_depth_written = r_o_wr;
    assign o_weight0       = r_o_w0;
    assign o_weight1       = r_o_w1;
    assign o_weight2       = r_o_w2;
    assign o_frag_depth    = r_o_z;

    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !wr_en)
        else $error("depth write during clear sweep");

    a_wr_implies_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_depth_written) |-> (o_covered && !o_off_screen))
        else $error("depth written without coverage");

    a_off_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_off_screen) |-> (!o_covered && o_frag_depth == 31'd0))
        else $error("off-screen result carries data");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_covered) |->
        (({1'b0, o_weight0} + {1'b0, o_weight1} + {1'b0, o_weight2}) <= tfdt_pkg::WEIGHT_ONE))
        else $error("weights exceed one");

    a_units_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfdt_pkg::ST_IDLE) |-> (!mul_done && !div_done))
        else $error("arithmetic unit finished while idle");

endmodule
